// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/swm_pkg.sv =====
package swm_pkg;

   localparam int CFG_WIDTH = 7;
   localparam logic [CFG_WIDTH-1:0] WINDOW_RESET = 7'd3;

   // Median pick is done in two registered levels: within a group, then across groups.
   localparam int GROUP_SPAN = 8;
   localparam int GROUP_SEL_WIDTH = 3;

   // Broadcast control to every cell of the sorted row.
   typedef struct packed {
      logic load;    // a sample beat is taken this cycle
      logic flush;   // the beat starts a new sequence
      logic full;    // window full: drop the oldest while inserting
      logic clear;   // register write: empty the row
   } swm_cell_ctl_type;

   // Flags a cell hands to its neighbors.
   typedef struct packed {
      logic left;    // cell lies left of the slot being vacated
      logic le;      // cell is kept and holds a value <= the new sample
   } swm_link_type;

endpackage

// ===== hdl/swm_if.sv =====
interface swm_req_if #(parameter int SAMPLE_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic                           start_req;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output start_req, output sample, input ready);
   modport sink   (input valid, input start_req, input sample, output ready);
endinterface

interface swm_rsp_if #(parameter int SAMPLE_WIDTH = 32);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] median;

   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface

interface swm_csr_if;
   logic                               valid;
   logic                               ready;
   logic [swm_pkg::CFG_WIDTH-1:0]      window_size;

   modport source (output valid, output window_size, input ready);
   modport sink   (input valid, input window_size, output ready);
endinterface

// ===== hdl/swm_ram.sv =====
module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/swm_cell.sv =====
module swm_cell #(
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  swm_pkg::swm_cell_ctl_type      ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   input  logic signed [SAMPLE_WIDTH-1:0] old_value,
   input  swm_pkg::swm_link_type          left_link,
   input  logic signed [SAMPLE_WIDTH-1:0] left_value,
   input  swm_pkg::swm_link_type          right_link,
   input  logic signed [SAMPLE_WIDTH-1:0] right_value,
   output swm_pkg::swm_link_type          link,
   output logic signed [SAMPLE_WIDTH-1:0] value
);
   import swm_pkg::*;

   logic                           valid_ff, valid_in;
   logic signed [SAMPLE_WIDTH-1:0] value_ff, value_in;
   logic                           live;
   logic                           hole;
   logic signed [SAMPLE_WIDTH-1:0] shifted;

   // The vacated slot is the leftmost copy of the oldest value, or the first
   // empty cell while the window fills.
   always_comb begin
      live      = valid_ff && !ctl.flush;
      link.left = ctl.full ? (live && (value_ff < old_value)) : live;
      hole      = !link.left && left_link.left;
      link.le   = live && !hole && (value_ff <= sample);
   end

   always_comb begin
      shifted = value_ff;
      if (link.left) begin
         // left of the vacated slot: shift right past the insertion point
         if (link.le) begin
            shifted = value_ff;
         end else if (left_link.le) begin
            shifted = sample;
         end else begin
            shifted = left_value;
         end
      end else begin
         // at or right of the vacated slot: pull from the right up to the insertion point
         if (right_link.le) begin
            shifted = right_value;
         end else if (hole ? left_link.le : link.le) begin
            shifted = sample;
         end else begin
            shifted = hole ? left_value : value_ff;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.load) begin
         valid_in = live || hole;
         value_in = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== hdl/swm_median_sel.sv =====
module swm_median_sel #(
   parameter int MAX_WINDOW   = 64,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic                                    clock,
   input  logic                                    load,
   input  logic [$clog2(MAX_WINDOW + 1)-1:0]       rank,
   input  logic signed [SAMPLE_WIDTH-1:0]          values [MAX_WINDOW],
   output logic signed [SAMPLE_WIDTH-1:0]          median
);
   import swm_pkg::*;

   localparam int GROUPS = (MAX_WINDOW + GROUP_SPAN - 1) / GROUP_SPAN;
   localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   logic signed [SAMPLE_WIDTH-1:0] grp_ff [GROUPS];
   logic signed [SAMPLE_WIDTH-1:0] grp_in [GROUPS];
   logic [GROUP_SEL_WIDTH-1:0]     sub;
   logic [GW-1:0]                  grp_idx;

   always_comb begin
      sub     = GROUP_SEL_WIDTH'(rank);
      grp_idx = GW'(rank >> GROUP_SEL_WIDTH);
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < GROUP_SPAN; k++) begin
            if ((g * GROUP_SPAN + k < MAX_WINDOW) && (sub == GROUP_SEL_WIDTH'(k))) begin
               grp_in[g] = values[g * GROUP_SPAN + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= grp_in;
      end
   end

   assign median = grp_ff[grp_idx];

endmodule

// ===== hdl/sliding_window_median.sv =====
// Sliding-window median filter.
// req_port carries one signed sample and a start flag per beat; rsp_port returns
// the lower median (rank (window-1)/2 ascending) of the last window_size samples.
// csr_port writes window_size (0 acts as 1, above MAX_WINDOW acts as MAX_WINDOW);
// each write also empties the window. Write it only while the block is idle.
// A start beat empties the window and opens a new sequence with its sample.
// No result comes until the window holds window_size samples of the sequence.
// A sample updates the sorted cell row when taken, then the median pick takes two
// registered levels, and req_port.ready stays low while that pick is in flight.
// The finished result sits in an output register, so a stalled receiver does not
// block the next sample; only a second result waiting behind it holds ready low.
// Reset empties the window, clears all pending results and sets window_size to 3.
// Sample storage needs no clearing pass after reset.
module sliding_window_median #(
   parameter int MAX_WINDOW   = 64,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic   clock,
   input  logic   reset,
   swm_req_if.sink     req_port,
   swm_rsp_if.source   rsp_port,
   swm_csr_if.sink     csr_port
);
   import swm_pkg::*;

   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   logic [CFG_WIDTH-1:0]           win_ff, win_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [AW-1:0]                  ptr_ff, ptr_in;
   logic [CW-1:0]                  eff;
   logic [CW-1:0]                  rank;
   logic                           accept, cfg_write, full, result;
   logic [AW-1:0]                  wr_addr;
   logic signed [SAMPLE_WIDTH-1:0] old_value;
   swm_cell_ctl_type               ctl;

   logic                           p1_ff, p1_res_ff, p1_in, p1_res_in;
   logic                           p2_ff, p2_res_ff, p2_in, p2_res_in;
   logic                           out_ff, out_in;
   logic signed [SAMPLE_WIDTH-1:0] median_ff, median_in;
   logic signed [SAMPLE_WIDTH-1:0] picked;
   logic                           p2_move;

   swm_link_type                   links  [MAX_WINDOW];
   logic signed [SAMPLE_WIDTH-1:0] values [MAX_WINDOW];

   assign csr_port.ready = 1'b1;
   assign cfg_write      = csr_port.valid && csr_port.ready;
   assign req_port.ready = !p1_ff && !p2_ff;
   assign accept         = req_port.valid && req_port.ready;

   always_comb begin
      if (win_ff == '0) begin
         eff = CW'(1);
      end else if (int'(win_ff) > MAX_WINDOW) begin
         eff = CW'(MAX_WINDOW);
      end else begin
         eff = CW'(win_ff);
      end
      rank = (eff - CW'(1)) >> 1;
   end

   always_comb begin
      full    = !req_port.start_req && (count_ff == eff);
      wr_addr = full ? ptr_ff : (req_port.start_req ? '0 : AW'(count_ff));
   end

   always_comb begin
      win_in   = win_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cfg_write) begin
         win_in   = csr_port.window_size;
         count_in = '0;
         ptr_in   = '0;
      end else if (accept) begin
         if (full) begin
            ptr_in = ((CW'(ptr_ff) + CW'(1)) == eff) ? '0 : ptr_ff + AW'(1);
         end else begin
            count_in = req_port.start_req ? CW'(1) : count_ff + CW'(1);
            ptr_in   = '0;
         end
      end
   end

   assign result = (count_in == eff);

   always_comb begin
      ctl.load  = accept;
      ctl.flush = req_port.start_req;
      ctl.full  = full;
      ctl.clear = cfg_write;
   end

   // The oldest sample is read ahead from history; the read data settles before
   // the next beat can be taken.
   swm_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_port.sample),
      .rd_addr (ptr_ff),
      .rd_data (old_value)
   );

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      swm_link_type                   l_link, r_link;
      logic signed [SAMPLE_WIDTH-1:0] l_value, r_value;

      if (i == 0) begin : g_head
         assign l_link  = '{left: 1'b1, le: 1'b1};
         assign l_value = '0;
      end else begin : g_mid_l
         assign l_link  = links[i-1];
         assign l_value = values[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_tail
         assign r_link  = '{left: 1'b0, le: 1'b0};
         assign r_value = '0;
      end else begin : g_mid_r
         assign r_link  = links[i+1];
         assign r_value = values[i+1];
      end

      swm_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .sample      (req_port.sample),
         .old_value   (old_value),
         .left_link   (l_link),
         .left_value  (l_value),
         .right_link  (r_link),
         .right_value (r_value),
         .link        (links[i]),
         .value       (values[i])
      );
   end

   swm_median_sel #(
      .MAX_WINDOW   (MAX_WINDOW),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_sel (
      .clock  (clock),
      .load   (p1_ff),
      .rank   (rank),
      .values (values),
      .median (picked)
   );

   // Hold the group stage while the output register is still owed to the receiver.
   assign p2_move = p2_ff && (!p2_res_ff || !out_ff || rsp_port.ready);

   always_comb begin
      p1_in     = accept;
      p1_res_in = accept ? result : p1_res_ff;
      p2_in     = p2_ff;
      p2_res_in = p2_res_ff;
      out_in    = out_ff;
      median_in = median_ff;
      if (out_ff && rsp_port.ready) begin
         out_in = 1'b0;
      end
      if (p2_move) begin
         p2_in = 1'b0;
         if (p2_res_ff) begin
            out_in    = 1'b1;
            median_in = picked;
         end
      end
      if (p1_ff) begin
         p2_in     = 1'b1;
         p2_res_in = p1_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= WINDOW_RESET;
         count_ff <= '0;
         ptr_ff   <= '0;
         p1_ff    <= 1'b0;
         p2_ff    <= 1'b0;
         out_ff   <= 1'b0;
      end else begin
         win_ff   <= win_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         out_ff   <= out_in;
      end
      p1_res_ff <= p1_res_in;
      p2_res_ff <= p2_res_in;
      median_ff <= median_in;
   end

   assign rsp_port.valid  = out_ff;
   assign rsp_port.median = median_ff;

endmodule

// ===== hdl/swm_checker.sv =====
`include "assert_macros.svh"

module swm_checker #(
   parameter int SAMPLE_WIDTH = 32
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] rsp_median
);

   logic req_beat;
   logic rsp_stall;

   assign req_beat  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "result dropped while stalled")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_median), "result changed while stalled")
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_beat, !req_ready, "sample taken while median pick busy")
   `ASSERT_SAME(a_rsp_origin, clock, reset, $rose(rsp_valid), $past(req_beat, 3), "result without sample beat three cycles earlier")

endmodule

bind sliding_window_median swm_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_swm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_port.valid),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_median (rsp_port.median)
);

// ===== test/sliding_window_median_tb.sv =====
module sliding_window_median_tb;

   localparam int MAX_WINDOW   = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int HOLD_CYCLES  = 160;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic                           start_req;
      logic signed [SAMPLE_WIDTH-1:0] sample;
   } sample_beat_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_type;

   logic clock;
   logic reset;

   swm_req_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) req_bus ();
   swm_rsp_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) rsp_bus ();
   swm_csr_if                                csr_bus ();

   sliding_window_median #(
      .MAX_WINDOW   (MAX_WINDOW),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // window state mirrored from the accepted beats
   logic [swm_pkg::CFG_WIDTH-1:0]  window_reg = swm_pkg::WINDOW_RESET;
   logic signed [SAMPLE_WIDTH-1:0] history_buf [MAX_WINDOW];
   logic signed [SAMPLE_WIDTH-1:0] ordered_buf [MAX_WINDOW];
   int                             fill_level  = 0;
   int                             oldest_slot = 0;

   logic signed [SAMPLE_WIDTH-1:0] medians_due [$];
   sample_beat_type                pending_beats [$];

   int  error_count  = 0;
   int  cycle_count  = 0;
   int  sent_count   = 0;
   int  taken_count  = 0;
   int  rsp_count    = 0;
   logic req_taken   = 1'b0;

   // sender burst state
   int burst_left = 0;
   int gap_left   = 0;

   // receiver stall state
   rx_mode_type stall_mode   = RX_OPEN;
   int          mode_left    = 0;
   int          hold_left    = 0;
   int          next_hold_at = 60;
   logic [3:0]  pulse_tick   = '0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int clamp_window(logic [swm_pkg::CFG_WIDTH-1:0] size);
      if (size == 0)
         return 1;
      if (size > MAX_WINDOW)
         return MAX_WINDOW;
      return int'(size);
   endfunction

   task automatic report_mismatch(string what);
      if (error_count < 30)
         $display("sliding_window_median_tb: mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   task automatic load_window(logic [swm_pkg::CFG_WIDTH-1:0] size);
      window_reg  = size;
      fill_level  = 0;
      oldest_slot = 0;
   endtask

   // sorted insert into the first n entries of the ordered store
   task automatic insert_ordered(logic signed [SAMPLE_WIDTH-1:0] s, int n);
      int i;
      i = n;
      while (i > 0 && s < ordered_buf[i-1]) begin
         ordered_buf[i] = ordered_buf[i-1];
         i--;
      end
      ordered_buf[i] = s;
   endtask

   task automatic predict_median(logic start_req, logic signed [SAMPLE_WIDTH-1:0] s);
      int w;
      int i;
      w = clamp_window(window_reg);
      if (start_req) begin
         fill_level  = 0;
         oldest_slot = 0;
      end
      if (fill_level > w)
         fill_level = w;
      if (oldest_slot >= w)
         oldest_slot = 0;
      if (fill_level == w) begin
         // drop one copy of the oldest sample, then insert the new one
         i = 0;
         while (i < w && ordered_buf[i] != history_buf[oldest_slot])
            i++;
         if (i >= w)
            i = w - 1;
         for (; i + 1 < w; i++)
            ordered_buf[i] = ordered_buf[i+1];
         history_buf[oldest_slot] = s;
         insert_ordered(s, w - 1);
         oldest_slot = (oldest_slot + 1 == w) ? 0 : oldest_slot + 1;
      end else begin
         history_buf[fill_level] = s;
         insert_ordered(s, fill_level);
         fill_level++;
         oldest_slot = 0;
      end
      if (fill_level == w)
         medians_due = {medians_due, ordered_buf[(w - 1) / 2]};
   endtask

   always @(posedge clock) begin : watch_ports
      logic signed [SAMPLE_WIDTH-1:0] want;
      cycle_count++;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (csr_bus.valid && csr_bus.ready)
            load_window(csr_bus.window_size);
         if (req_bus.valid && req_bus.ready) begin
            taken_count++;
            predict_median(req_bus.start_req, req_bus.sample);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_count++;
            if (medians_due.size() == 0) begin
               report_mismatch($sformatf("median beat %0d with none expected",
                                         rsp_bus.median));
            end else begin
               want = medians_due.pop_front();
               if (rsp_bus.median !== want)
                  report_mismatch($sformatf("median %0d, expected %0d",
                                            rsp_bus.median, want));
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sliding_window_median_tb: FAIL");
         $finish;
      end
   end

   // sender: bursts of random length separated by random gaps
   always @(negedge clock) begin : drive_samples
      logic            offer;
      sample_beat_type beat;
      offer = req_bus.valid;
      beat  = {req_bus.start_req, req_bus.sample};
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_taken)
            offer = 1'b0;
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_beats.size() > 0) begin
               beat  = pending_beats.pop_front();
               offer = 1'b1;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_bus.valid     <= offer;
      req_bus.start_req <= beat.start_req;
      req_bus.sample    <= beat.sample;
   end

   // receiver: its own stall pattern, plus long hold-offs that back up the block
   always @(negedge clock) begin : accept_medians
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_count >= next_hold_at) begin
         hold_left    = HOLD_CYCLES;
         next_hold_at = next_hold_at + 650;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(10, 80);
         end
         mode_left--;
         pulse_tick++;
         case (stall_mode)
            RX_OPEN:   rsp_bus.ready <= 1'b1;
            RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_bus.ready <= ($urandom_range(0, 5) == 0);
            default:   rsp_bus.ready <= pulse_tick[1];
         endcase
      end
   end

   task automatic queue_beat(logic start_req, logic signed [SAMPLE_WIDTH-1:0] s);
      sample_beat_type beat;
      beat          = {start_req, s};
      pending_beats = {pending_beats, beat};
      sent_count++;
   endtask

   task automatic write_window(logic [swm_pkg::CFG_WIDTH-1:0] size);
      @(negedge clock);
      csr_bus.window_size = size;
      csr_bus.valid       = 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // hold until every beat is taken and every median is back, then let the pipe drain
   task automatic wait_idle();
      while (taken_count != sent_count || medians_due.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample(
      logic signed [SAMPLE_WIDTH-1:0] last);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom;
         5, 6, 7:       return int'($urandom_range(0, 6)) - 3;
         8: begin
            case ($urandom_range(0, 3))
               0:       return SAMPLE_MIN;
               1:       return SAMPLE_MAX;
               2:       return '0;
               default: return '1;
            endcase
         end
         default:       return last;
      endcase
   endfunction

   initial begin : stimulus
      logic [swm_pkg::CFG_WIDTH-1:0]  sizes [12];
      logic signed [SAMPLE_WIDTH-1:0] s;
      logic                           st;
      int                             w;
      int                             seq_left;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.start_req     = 1'b0;
      req_bus.sample        = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.window_size   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset window of three: extremes, duplicates, starts while filling and while full
      queue_beat(1'b1, SAMPLE_MIN);
      queue_beat(1'b0, SAMPLE_MAX);
      queue_beat(1'b0, '0);
      queue_beat(1'b0, '1);
      queue_beat(1'b0, '1);
      queue_beat(1'b0, '1);
      queue_beat(1'b0, SAMPLE_MIN);
      queue_beat(1'b1, 5);
      queue_beat(1'b0, 6);
      queue_beat(1'b1, 7);
      queue_beat(1'b0, 7);
      queue_beat(1'b0, 7);
      queue_beat(1'b0, SAMPLE_MAX);
      queue_beat(1'b0, SAMPLE_MAX);
      queue_beat(1'b0, SAMPLE_MAX);
      queue_beat(1'b0, 1);
      queue_beat(1'b0, 32'h4000_0000);
      queue_beat(1'b0, 32'hAAAA_AAAA);
      queue_beat(1'b0, 32'h5555_5555);
      queue_beat(1'b0, SAMPLE_MIN + 1);
      queue_beat(1'b0, SAMPLE_MAX - 1);
      wait_idle();

      sizes = '{7'd1, 7'd2, 7'd0, 7'd127, 7'd5, 7'd64, 7'd4, 7'd3, 7'd9, 7'd32,
                7'd0, 7'd0};
      sizes[10] = 7'($urandom_range(1, 127));
      sizes[11] = 7'($urandom_range(1, 16));

      s = '0;
      foreach (sizes[p]) begin
         write_window(sizes[p]);
         w        = clamp_window(sizes[p]);
         seq_left = 0;
         for (int n = 0; n < 160; n++) begin
            if (seq_left == 0) begin
               st = 1'b1;
               // mostly full sequences, some cut short before the window fills
               seq_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w)
                                                       : w + $urandom_range(0, 2 * w + 8);
            end else begin
               st = ($urandom_range(0, 29) == 0);
            end
            // the write has just emptied the window, so the flag is free here
            if (n == 0)
               st = 1'($urandom_range(0, 1));
            seq_left--;
            s = random_sample(s);
            queue_beat(st, s);
         end
         wait_idle();
      end

      if (medians_due.size() != 0)
         report_mismatch($sformatf("%0d medians never arrived", medians_due.size()));
      if (error_count == 0)
         $display("sliding_window_median_tb: PASS");
      else
         $display("sliding_window_median_tb: FAIL");
      $finish;
   end

endmodule
